[sv/three_channel_reload_timer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three-channel reload timer
// Implication checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_RELOAD_TIMER_ASSERT_SVH
`define THREE_CHANNEL_RELOAD_TIMER_ASSERT_SVH

// Same-cycle implication.
`define TCRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tcrt_pkg.sv]
// ----------------------------------------------------------------------------
// tcrt_pkg
// Shared types, register map and codes of the three-channel reload timer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrt_pkg;

  localparam int NUM_CH             = 3;
  localparam int CTRL_W             = 10;
  localparam int DEFAULT_BASE_SHIFT = 2;

  // Function codes of a request
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Register map, matched after forcing the top address nibble
  localparam logic [31:0] ADDR_OR = 32'hF000_0000;
  localparam logic [31:0] A_TOCR  = 32'hFFD8_0000;
  localparam logic [31:0] A_TSTR  = 32'hFFD8_0004;
  localparam logic [31:0] A_TCOR [NUM_CH] = '{32'hFFD8_0008, 32'hFFD8_0014, 32'hFFD8_0020};
  localparam logic [31:0] A_TCNT [NUM_CH] = '{32'hFFD8_000C, 32'hFFD8_0018, 32'hFFD8_0024};
  localparam logic [31:0] A_TCR  [NUM_CH] = '{32'hFFD8_0010, 32'hFFD8_001C, 32'hFFD8_0028};

  // Control word fields and write masks
  localparam int UNIE_BIT = 5;
  localparam int UNF_BIT  = 8;
  localparam logic [CTRL_W-1:0] MASK_CH2  = 10'h3FF;
  localparam logic [CTRL_W-1:0] MASK_CH01 = 10'h13F;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
    logic [2:0]  irq;
  } rsp_t;

  // Address decode result
  typedef struct packed {
    logic              tocr;
    logic              tstr;
    logic [NUM_CH-1:0] tcor;
    logic [NUM_CH-1:0] tcnt;
    logic [NUM_CH-1:0] tcr;
  } dec_t;

  // Per-channel strobes for one request
  typedef struct packed {
    logic run;
    logic restart;
    logic wr_tcr;
    logic wr_tcnt;
    logic wr_tcor;
  } ch_cmd_t;

  typedef struct packed {
    logic [31:0]       count;
    logic [CTRL_W-1:0] ctrl;
    logic              irq_next;
  } ch_stat_t;

endpackage

`default_nettype wire

[sv/tcrt_decode.sv]
// ----------------------------------------------------------------------------
// tcrt_decode
// Register address decoder of the timer's bus map.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrt_decode import tcrt_pkg::*; (
  input  wire logic [31:0] addr,
  output dec_t             dec
);

  logic [31:0] a;

  assign a = addr | ADDR_OR;

  always_comb begin
    dec      = '0;
    dec.tocr = (a == A_TOCR);
    dec.tstr = (a == A_TSTR);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dec.tcor[ch] = (a == A_TCOR[ch]);
      dec.tcnt[ch] = (a == A_TCNT[ch]);
      dec.tcr[ch]  = (a == A_TCR[ch]);
    end
  end

endmodule

`default_nettype wire

[sv/tcrt_channel.sv]
// ----------------------------------------------------------------------------
// tcrt_channel
// One timer channel: prescaler, down-counter, reload and control word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrt_channel import tcrt_pkg::*; #(
  parameter int                BASE_SHIFT = DEFAULT_BASE_SHIFT,
  parameter logic [CTRL_W-1:0] WR_MASK    = MASK_CH01
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ch_cmd_t     cmd,
  input  wire logic [31:0] wdata,
  output ch_stat_t         stat
);

  // Longest period is 2^(BASE_SHIFT+10); the phase never reaches it
  localparam int PHASE_W = BASE_SHIFT + 10;
  localparam int SHIFT_W = $clog2(PHASE_W + 1);

  logic [31:0]        count, count_next;
  logic [31:0]        reload, reload_next;
  logic [CTRL_W-1:0]  ctrl, ctrl_next;
  logic [PHASE_W-1:0] phase, phase_next;

  logic [2:0]         tpsc;
  logic [SHIFT_W-1:0] shift;
  logic [PHASE_W:0]   period;
  logic [PHASE_W:0]   phase_inc;

  assign tpsc      = ctrl[2:0];
  assign shift     = (tpsc <= 3'd4) ? SHIFT_W'(BASE_SHIFT + 2 + 2 * int'(tpsc))
                                    : SHIFT_W'(BASE_SHIFT);
  assign period    = {{PHASE_W{1'b0}}, 1'b1} << shift;
  assign phase_inc = {1'b0, phase} + {{PHASE_W{1'b0}}, 1'b1};

  always_comb begin
    count_next  = count;
    reload_next = reload;
    ctrl_next   = ctrl;
    phase_next  = phase;
    if (cmd.run) begin
      if (phase_inc >= period) begin
        phase_next = '0;
        if (count == '0) begin
          ctrl_next[UNF_BIT] = 1'b1;
          count_next         = reload;
        end else begin
          count_next = count - 32'd1;
        end
      end else begin
        phase_next = phase_inc[PHASE_W-1:0];
      end
    end
    if (cmd.restart) begin
      phase_next = '0;
    end
    if (cmd.wr_tcr) begin
      ctrl_next  = wdata[CTRL_W-1:0] & WR_MASK;
      phase_next = '0;
    end
    if (cmd.wr_tcnt) begin
      count_next = wdata;
      phase_next = '0;
    end
    if (cmd.wr_tcor) begin
      reload_next = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '1;
      reload <= '1;
      ctrl   <= '0;
      phase  <= '0;
    end else begin
      count  <= count_next;
      reload <= reload_next;
      ctrl   <= ctrl_next;
      phase  <= phase_next;
    end
  end

  assign stat.count    = count;
  assign stat.ctrl     = ctrl;
  assign stat.irq_next = ctrl_next[UNF_BIT] & ctrl_next[UNIE_BIT];

endmodule

`default_nettype wire

[sv/three_channel_reload_timer.sv]
// ----------------------------------------------------------------------------
// three_channel_reload_timer
// Three 32-bit reload down-counters behind a memory-mapped register bus.
// ----------------------------------------------------------------------------
// Each request is a clock tick, a register read or a register write and
// yields exactly one response, in order. The block takes one request per
// cycle while the output register is not stalled: a request waits in the
// input register, where the decoder and the channel update logic form its
// effect on the channel state and its response; the response then lands in
// the output register when the pipe advances, which raises rsp_valid.
// A stalled response holds the pipe, and req_stall rises only while the
// input register is full and the full output register is stalled.
// Reads return the state before the request; irq reflects the state after
// it. TOCR and TCOR are write only.
`default_nettype none

module three_channel_reload_timer import tcrt_pkg::*; #(
  parameter int BASE_SHIFT = DEFAULT_BASE_SHIFT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // Input register
  logic     s_valid;
  req_t     s_req;

  logic     advance;
  logic     fire;

  // Timer-wide registers
  logic [7:0] start_bits, start_bits_next;
  logic [7:0] output_control, output_control_next;

  dec_t     dec;
  ch_cmd_t  cmd  [NUM_CH];
  ch_stat_t stat [NUM_CH];

  rsp_t     rsp_next;
  logic     is_tick, is_read, is_write;

  // Move the pipe whenever the output register is free or being drained
  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = s_valid && advance;
  assign req_stall = s_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!req_stall) begin
      s_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s_req <= req;
    end
  end

  tcrt_decode u_decode (
    .addr (s_req.addr),
    .dec  (dec)
  );

  assign is_tick  = fire && (s_req.func == FUNC_TICK);
  assign is_read  = fire && (s_req.func == FUNC_READ);
  assign is_write = fire && (s_req.func == FUNC_WRITE);

  // Build the per-channel strobes; a start bit going from 0 to 1 restarts
  // the prescaler phase
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cmd[ch].run     = is_tick && start_bits[ch];
      cmd[ch].restart = is_write && dec.tstr && !start_bits[ch] && s_req.wdata[ch];
      cmd[ch].wr_tcr  = is_write && dec.tcr[ch];
      cmd[ch].wr_tcnt = is_write && dec.tcnt[ch];
      cmd[ch].wr_tcor = is_write && dec.tcor[ch];
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    tcrt_channel #(
      .BASE_SHIFT (BASE_SHIFT),
      .WR_MASK    ((ch == 2) ? MASK_CH2 : MASK_CH01)
    ) u_channel (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd[ch]),
      .wdata (s_req.wdata),
      .stat  (stat[ch])
    );
  end

  // Start and output-control registers; output control is stored only
  always_comb begin
    start_bits_next     = start_bits;
    output_control_next = output_control;
    if (is_write && dec.tstr) begin
      start_bits_next = s_req.wdata[7:0];
    end
    if (is_write && dec.tocr) begin
      output_control_next = s_req.wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_bits     <= '0;
      output_control <= '0;
    end else begin
      start_bits     <= start_bits_next;
      output_control <= output_control_next;
    end
  end

  // Form the response: read mux on the pre-request state, irq after it
  always_comb begin
    rsp_next = '0;
    case (s_req.func)
      FUNC_TICK: begin
        rsp_next.hit = 1'b1;
      end
      FUNC_READ: begin
        if (dec.tstr) begin
          rsp_next.hit   = 1'b1;
          rsp_next.rdata = {24'd0, start_bits};
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (dec.tcr[ch]) begin
            rsp_next.hit   = 1'b1;
            rsp_next.rdata = {{(32 - CTRL_W){1'b0}}, stat[ch].ctrl};
          end
          if (dec.tcnt[ch]) begin
            rsp_next.hit   = 1'b1;
            rsp_next.rdata = stat[ch].count;
          end
        end
      end
      FUNC_WRITE: begin
        rsp_next.hit = dec.tocr || dec.tstr || (|dec.tcor) || (|dec.tcnt) || (|dec.tcr);
      end
      default: begin
        rsp_next.hit = 1'b0;
      end
    endcase
    for (int ch = 0; ch < NUM_CH; ch++) begin
      rsp_next.irq[ch] = stat[ch].irq_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  `include "three_channel_reload_timer_assert.svh"

  // Nonzero read data only ever comes with a decoded register
  `TCRT_ASSERT_NOW(a_rdata_needs_hit, rsp_valid && (rsp.rdata != 32'd0), rsp.hit, "rdata without hit")
  // A tick always produces a hit response in the next cycle
  `TCRT_ASSERT_NEXT(a_tick_hits, is_tick, rsp_valid && rsp.hit, "tick response lost or missed")
  // An accepted request is held in the input register
  `TCRT_ASSERT_NEXT(a_accept_loads, req_valid && !req_stall, s_valid, "accepted request dropped")
  // Channels advance their prescaler only on a tick
  `TCRT_ASSERT_NOW(a_run_needs_start, fire && (s_req.func != FUNC_TICK), !cmd[0].run && !cmd[1].run && !cmd[2].run, "channel run outside a tick")

endmodule

`default_nettype wire
